[src/i2a_pkg.sv]
// Shared types, constants and a helper function for the integer to ASCII formatter.
package i2a_pkg;

	// Widths of the input value and of one digit cell.
	localparam int VALUE_W   = 64;
	localparam int HALF_W    = 32;
	localparam int DIGIT_W   = 4;
	// Enough decimal digits for the largest 64-bit magnitude.
	localparam int NUM_CELLS = 20;
	localparam int HEX_CELLS = VALUE_W / DIGIT_W;
	localparam int CNT_W     = $clog2(VALUE_W + 1);
	localparam int REM_W     = $clog2(NUM_CELLS + 1);

	// Format selector codes; codes five to seven behave as unsigned decimal.
	localparam logic [2:0] MODE_SDEC = 3'd0;
	localparam logic [2:0] MODE_UDEC = 3'd1;
	localparam logic [2:0] MODE_HEXL = 3'd2;
	localparam logic [2:0] MODE_HEXU = 3'd3;
	localparam logic [2:0] MODE_PTR  = 3'd4;

	// Fixed characters.
	localparam logic [7:0] CHAR_ZERO  = 8'h30;
	localparam logic [7:0] CHAR_MINUS = 8'h2d;
	localparam logic [7:0] CHAR_X     = 8'h78;
	localparam logic [7:0] CHAR_UA    = 8'h41;
	localparam logic [7:0] CHAR_LA    = 8'h61;

	// Control for the digit cells, common to the whole row.
	typedef struct packed {
		logic load;
		logic dabble;
		logic shift;
	} cell_ctrl_t;

	// Maps one digit to its ASCII character.
	function automatic logic [7:0] digit_char(input logic [DIGIT_W-1:0] d, input logic upper);
		logic [7:0] ext;
		ext = {{(8 - DIGIT_W){1'b0}}, d};
		if (d < 4'd10) begin
			return CHAR_ZERO + ext;
		end
		return (upper ? CHAR_UA : CHAR_LA) + ext - 8'd10;
	endfunction

endpackage

[src/i2a_cell.sv]
// One digit cell: holds a digit, runs one shift-and-add-three step or passes its digit on.
module i2a_cell (
	input  logic                          clk,
	input  i2a_pkg::cell_ctrl_t           ctrl,
	input  logic [i2a_pkg::DIGIT_W-1:0]   load_digit,
	input  logic                          bit_in,
	input  logic [i2a_pkg::DIGIT_W-1:0]   digit_in,
	output logic                          bit_out,
	output logic [i2a_pkg::DIGIT_W-1:0]   digit
);

	logic [i2a_pkg::DIGIT_W-1:0] digit_q;
	logic [i2a_pkg::DIGIT_W-1:0] adj;

	// A digit of five or more gets three added so that the shift carries correctly.
	assign adj     = (digit_q >= 4'd5) ? digit_q + 4'd3 : digit_q;
	assign bit_out = adj[i2a_pkg::DIGIT_W-1];
	assign digit   = digit_q;

	// Digit register: load, conversion step, or move to the next cell up.
	always_ff @(posedge clk) begin
		if (ctrl.load) begin
			digit_q <= load_digit;
		end else if (ctrl.dabble) begin
			digit_q <= {adj[i2a_pkg::DIGIT_W-2:0], bit_in};
		end else if (ctrl.shift) begin
			digit_q <= digit_in;
		end
	end

endmodule

[src/integer_to_ascii_formatter.sv]
// Top level of the integer to ASCII formatter: control, digit cell row and output register.
//
// Channel | Handshake              | Payload            | Beat
// item    | item_valid, item_ready | mode, value        | one number to format
// char    | char_valid, char_ready | character, last    | one character, last marks the end
//
// A number is taken from the item channel, then any prefix goes out one character
// a cycle while char_ready allows. Decimal runs one bit a cycle through the digit
// cells: all 64 bits for mode 0, the low 32 for the other decimal modes. Leading
// zeros are then shifted out of the top cell, one per cycle, up to 19 of them, and
// the skip state then finds the first digit. Each digit then leaves at one a cycle
// while char_ready is high; a stalled output register holds the whole row.
// Reset clears the controller and the output valid; a new number is taken once the
// last character of the previous one sits in the output register.
module integer_to_ascii_formatter (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        item_valid,
	output logic        item_ready,
	input  logic [2:0]  mode,
	input  logic [63:0] value,
	output logic        char_valid,
	input  logic        char_ready,
	output logic [7:0]  character,
	output logic        last
);

	typedef enum logic [4:0] {
		ST_IDLE = 5'b00001,
		ST_PRE  = 5'b00010,
		ST_CONV = 5'b00100,
		ST_SKIP = 5'b01000,
		ST_EMIT = 5'b10000
	} state_t;

	localparam int NC = i2a_pkg::NUM_CELLS;
	localparam int DW = i2a_pkg::DIGIT_W;
	localparam int VW = i2a_pkg::VALUE_W;
	localparam int HW = i2a_pkg::HALF_W;

	state_t                    state_q, state_d;
	logic [VW-1:0]             sr_q, sr_d;
	logic [i2a_pkg::CNT_W-1:0] cnt_q, cnt_d;
	logic [i2a_pkg::REM_W-1:0] rem_q, rem_d;
	logic [1:0]                pre_q, pre_d;
	logic                      ptr_q, ptr_d;
	logic                      upper_q, upper_d;
	logic                      dec_q, dec_d;
	logic [7:0]                char_q, char_d;
	logic                      last_q, last_d;
	logic                      valid_q;

	i2a_pkg::cell_ctrl_t       ctrl;
	logic [DW-1:0]             digits [NC];
	logic [DW-1:0]             ld_digits [NC];
	logic                      bits [NC];
	logic [DW-1:0]             top_digit;
	logic [VW-1:0]             hex_src;
	logic [VW-1:0]             mag;
	logic                      accept;
	logic                      out_load;
	logic                      char_load;
	logic                      in_neg;
	logic                      in_dec;
	logic                      in_ptr;

	assign item_ready = (state_q == ST_IDLE);
	assign accept     = item_valid && item_ready;
	assign out_load   = !valid_q || char_ready;
	assign top_digit  = digits[NC-1];
	assign char_valid = valid_q;
	assign character  = char_q;
	assign last       = last_q;

	// Decode of the incoming number.
	assign in_neg  = (mode == i2a_pkg::MODE_SDEC) && value[VW-1];
	assign in_ptr  = (mode == i2a_pkg::MODE_PTR);
	assign in_dec  = !(in_ptr || mode == i2a_pkg::MODE_HEXL || mode == i2a_pkg::MODE_HEXU);
	assign mag     = in_neg ? (~value + 64'd1) : value;
	assign hex_src = in_dec ? '0 : (in_ptr ? value : {{(VW - HW){1'b0}}, value[HW-1:0]});

	// Row of digit cells, least significant at index zero.
	for (genvar i = 0; i < NC; i++) begin : g_cell
		if (i < i2a_pkg::HEX_CELLS) begin : g_hex
			assign ld_digits[i] = hex_src[DW*i +: DW];
		end else begin : g_pad
			assign ld_digits[i] = '0;
		end
		if (i == 0) begin : g_first
			i2a_cell u_cell (
				.clk        (clk),
				.ctrl       (ctrl),
				.load_digit (ld_digits[i]),
				.bit_in     (sr_q[VW-1]),
				.digit_in   ({DW{1'b0}}),
				.bit_out    (bits[i]),
				.digit      (digits[i])
			);
		end else begin : g_rest
			i2a_cell u_cell (
				.clk        (clk),
				.ctrl       (ctrl),
				.load_digit (ld_digits[i]),
				.bit_in     (bits[i-1]),
				.digit_in   (digits[i-1]),
				.bit_out    (bits[i]),
				.digit      (digits[i])
			);
		end
	end

	// Sequencer: prefix, conversion, leading zero skip, then digits out.
	always_comb begin
		state_d   = state_q;
		sr_d      = sr_q;
		cnt_d     = cnt_q;
		rem_d     = rem_q;
		pre_d     = pre_q;
		ptr_d     = ptr_q;
		upper_d   = upper_q;
		dec_d     = dec_q;
		char_d    = char_q;
		last_d    = last_q;
		char_load = 1'b0;
		ctrl      = '0;
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					ctrl.load = 1'b1;
					dec_d     = in_dec;
					ptr_d     = in_ptr;
					upper_d   = (mode == i2a_pkg::MODE_HEXU);
					rem_d     = i2a_pkg::REM_W'(NC);
					pre_d     = in_ptr ? 2'd2 : (in_neg ? 2'd1 : 2'd0);
					if (mode == i2a_pkg::MODE_SDEC) begin
						sr_d  = mag;
						cnt_d = i2a_pkg::CNT_W'(VW);
					end else begin
						sr_d  = {value[HW-1:0], {(VW - HW){1'b0}}};
						cnt_d = i2a_pkg::CNT_W'(HW);
					end
					if (in_ptr || in_neg) begin
						state_d = ST_PRE;
					end else if (in_dec) begin
						state_d = ST_CONV;
					end else begin
						state_d = ST_SKIP;
					end
				end
			end
			ST_PRE: begin
				if (out_load) begin
					char_load = 1'b1;
					last_d    = 1'b0;
					if (ptr_q) begin
						char_d = (pre_q == 2'd2) ? i2a_pkg::CHAR_ZERO : i2a_pkg::CHAR_X;
					end else begin
						char_d = i2a_pkg::CHAR_MINUS;
					end
					pre_d = pre_q - 2'd1;
					if (pre_q == 2'd1) begin
						state_d = dec_q ? ST_CONV : ST_SKIP;
					end
				end
			end
			ST_CONV: begin
				ctrl.dabble = 1'b1;
				sr_d        = {sr_q[VW-2:0], 1'b0};
				cnt_d       = cnt_q - i2a_pkg::CNT_W'(1);
				if (cnt_q == i2a_pkg::CNT_W'(1)) begin
					state_d = ST_SKIP;
				end
			end
			ST_SKIP: begin
				if (top_digit == '0 && rem_q > i2a_pkg::REM_W'(1)) begin
					ctrl.shift = 1'b1;
					rem_d      = rem_q - i2a_pkg::REM_W'(1);
				end else begin
					state_d = ST_EMIT;
				end
			end
			ST_EMIT: begin
				if (out_load) begin
					char_load  = 1'b1;
					ctrl.shift = 1'b1;
					char_d     = i2a_pkg::digit_char(top_digit, upper_q);
					last_d     = (rem_q == i2a_pkg::REM_W'(1));
					rem_d      = rem_q - i2a_pkg::REM_W'(1);
					if (rem_q == i2a_pkg::REM_W'(1)) begin
						state_d = ST_IDLE;
					end
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// Control registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (out_load) begin
				valid_q <= char_load;
			end
		end
	end

	// Working and output payload registers.
	always_ff @(posedge clk) begin
		sr_q    <= sr_d;
		cnt_q   <= cnt_d;
		rem_q   <= rem_d;
		pre_q   <= pre_d;
		ptr_q   <= ptr_d;
		upper_q <= upper_d;
		dec_q   <= dec_d;
		char_q  <= char_d;
		last_q  <= last_d;
	end

`ifndef ASSERT_OFF
	// A taken number always starts work on the next cycle.
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> state_q != ST_IDLE)
		else $error("formatter stayed idle after taking a number");

	// Digits remain whenever characters are being sent.
	a_emit_rem: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_EMIT |-> rem_q != '0)
		else $error("digit count ran out while sending");

	// Conversion never runs with its bit count exhausted.
	a_conv_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_CONV |-> cnt_q != '0)
		else $error("conversion ran past its bit count");

	// After conversion the top decimal cell holds a valid decimal digit.
	a_dec_digit: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SKIP || state_q == ST_EMIT) && dec_q |-> top_digit < 4'd10)
		else $error("decimal cell holds a digit above nine");
`endif

endmodule
